// ===== rtl/nltsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nltsc_pkg
// Shared types and constants for the length-prefix to start-code converter.
// ----------------------------------------------------------------------------
package nltsc_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [2:0] PREFIX_MIN   = 3'd1;
    localparam logic [2:0] PREFIX_MAX   = 3'd4;
    localparam logic [2:0] PREFIX_RESET = 3'd4;

    localparam logic [7:0] START_CODE [4] = '{8'h00, 8'h00, 8'h00, 8'h01};

    typedef enum logic [1:0] {
        CMD_BYTE   = 2'd0,
        CMD_START  = 2'd1,
        CMD_STATUS = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data;
        logic        sample_end;
        logic        malformed;
    } cmd_t;

endpackage

// ===== rtl/nltsc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nltsc_front
// Parses sample bytes, tracks length prefixes and issues output commands.
// ----------------------------------------------------------------------------
module nltsc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_data_byte,
    input  logic              s_sample_first,
    input  logic [31:0]       s_sample_size,
    input  logic              q_full,
    output logic              q_push,
    output nltsc_pkg::cmd_t   q_cmd
);
    import nltsc_pkg::*;

    typedef enum logic [2:0] {
        PH_LEN  = 3'b001,
        PH_PAY  = 3'b010,
        PH_DROP = 3'b100
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] accum_reg, accum_next;
    logic [2:0]  seen_reg, seen_next;
    logic [31:0] pay_left_reg, pay_left_next;
    logic [31:0] smp_left_reg, smp_left_next;
    logic        bad_reg, bad_next;
    logic [2:0]  prefix_reg;

    logic        accept;
    logic [2:0]  pfx;
    logic [31:0] remain;
    logic [31:0] shifted;
    logic [2:0]  seen_inc;
    logic [31:0] pay_dec;
    logic        last;
    logic        emit;
    cmd_kind_t   kind;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;

    // saturate out-of-range prefix sizes
    always_comb begin
        if (prefix_reg < PREFIX_MIN) begin
            pfx = PREFIX_MIN;
        end else if (prefix_reg > PREFIX_MAX) begin
            pfx = PREFIX_MAX;
        end else begin
            pfx = prefix_reg;
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        accum_next    = accum_reg;
        seen_next     = seen_reg;
        pay_left_next = pay_left_reg;
        smp_left_next = smp_left_reg;
        bad_next      = bad_reg;
        emit          = 1'b0;
        kind          = CMD_STATUS;
        last          = 1'b0;
        remain        = smp_left_reg;
        shifted       = '0;
        seen_inc      = '0;
        pay_dec       = '0;

        if (accept) begin
            if (s_sample_first) begin
                remain        = (s_sample_size != 32'd0) ? s_sample_size : 32'd1;
                phase_next    = PH_LEN;
                accum_next    = '0;
                seen_next     = '0;
                pay_left_next = '0;
                bad_next      = 1'b0;
            end
            // bytes outside any sample are dropped quietly
            if (remain != 32'd0) begin
                smp_left_next = remain - 32'd1;
                last          = (remain == 32'd1);
                case (phase_next)
                    PH_LEN: begin
                        if (seen_next == 3'd0 && remain < {29'd0, pfx}) begin
                            bad_next   = 1'b1;
                            phase_next = PH_DROP;
                        end else begin
                            shifted    = {accum_next[23:0], s_data_byte};
                            seen_inc   = (seen_next < 3'd7) ? seen_next + 3'd1 : seen_next;
                            accum_next = shifted;
                            seen_next  = seen_inc;
                            if (seen_inc >= pfx) begin
                                // length must fit in the bytes left after this one
                                if (shifted == 32'd0 || shifted >= remain) begin
                                    bad_next   = 1'b1;
                                    phase_next = PH_DROP;
                                end else begin
                                    emit          = 1'b1;
                                    kind          = CMD_START;
                                    pay_left_next = shifted;
                                    phase_next    = PH_PAY;
                                end
                            end
                        end
                    end
                    PH_PAY: begin
                        emit    = 1'b1;
                        kind    = CMD_BYTE;
                        pay_dec = (pay_left_next != 32'd0) ? pay_left_next - 32'd1
                                                           : pay_left_next;
                        pay_left_next = pay_dec;
                        if (pay_dec == 32'd0) begin
                            phase_next = PH_LEN;
                            accum_next = '0;
                            seen_next  = '0;
                        end
                    end
                    default: begin
                    end
                endcase
                if (last) begin
                    emit = 1'b1;
                end
            end else begin
                smp_left_next = remain;
            end
        end
    end

    assign q_push          = emit;
    assign q_cmd.kind      = kind;
    assign q_cmd.data      = (kind == CMD_BYTE) ? s_data_byte : 8'h00;
    assign q_cmd.sample_end = last;
    assign q_cmd.malformed = last && bad_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_LEN;
            accum_reg    <= '0;
            seen_reg     <= '0;
            pay_left_reg <= '0;
            smp_left_reg <= '0;
            bad_reg      <= 1'b0;
            prefix_reg   <= PREFIX_RESET;
        end else begin
            phase_reg    <= phase_next;
            accum_reg    <= accum_next;
            seen_reg     <= seen_next;
            pay_left_reg <= pay_left_next;
            smp_left_reg <= smp_left_next;
            bad_reg      <= bad_next;
            if (cfg_valid && cfg_ready) begin
                prefix_reg <= cfg_data;
            end
        end
    end

endmodule

// ===== rtl/nltsc_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nltsc_cmd_fifo
// Short command queue between the parser and the output sequencer.
// ----------------------------------------------------------------------------
module nltsc_cmd_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  nltsc_pkg::cmd_t   push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output nltsc_pkg::cmd_t   head_cmd
);
    import nltsc_pkg::*;

    cmd_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + FIFO_CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - FIFO_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
        end
    end

endmodule

// ===== rtl/nltsc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nltsc_back
// Expands queued commands into result transfers through an output register.
// ----------------------------------------------------------------------------
module nltsc_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  nltsc_pkg::cmd_t   head_cmd,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte,
    output logic              m_byte_valid,
    output logic              m_nal_start,
    output logic              m_sample_end,
    output logic              m_malformed,
    output logic              m_run_last
);
    import nltsc_pkg::*;

    logic [1:0] beat_reg, beat_next;
    logic       m_valid_reg;
    logic [7:0] byte_reg;
    logic       bvalid_reg, nstart_reg, send_reg, malf_reg, rlast_reg;

    logic       load;
    logic       last_beat;
    logic [7:0] beat_byte;
    logic       beat_bvalid;
    logic       beat_nstart;

    assign load = !m_valid_reg || m_ready;

    always_comb begin
        last_beat   = 1'b1;
        beat_byte   = 8'h00;
        beat_bvalid = 1'b0;
        beat_nstart = 1'b0;
        case (head_cmd.kind)
            CMD_START: begin
                beat_byte   = START_CODE[beat_reg];
                beat_bvalid = 1'b1;
                beat_nstart = (beat_reg == 2'd0);
                last_beat   = (beat_reg == 2'd3);
            end
            CMD_BYTE: begin
                beat_byte   = head_cmd.data;
                beat_bvalid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign pop = load && head_valid && last_beat;

    always_comb begin
        beat_next = beat_reg;
        if (load && head_valid) begin
            beat_next = last_beat ? 2'd0 : beat_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            beat_reg    <= '0;
        end else begin
            beat_reg <= beat_next;
            if (load) begin
                m_valid_reg <= head_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && head_valid) begin
            byte_reg   <= beat_byte;
            bvalid_reg <= beat_bvalid;
            nstart_reg <= beat_nstart;
            send_reg   <= last_beat && head_cmd.sample_end;
            malf_reg   <= last_beat && head_cmd.malformed;
            rlast_reg  <= last_beat;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = byte_reg;
    assign m_byte_valid = bvalid_reg;
    assign m_nal_start  = nstart_reg;
    assign m_sample_end = send_reg;
    assign m_malformed  = malf_reg;
    assign m_run_last   = rlast_reg;

endmodule

// ===== rtl/nal_length_to_start_code.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nal_length_to_start_code
// Converts length-prefixed NAL unit samples into a start-code byte stream.
// Each result passes through the command queue and then the output register.
// Throughput: one input byte per cycle while the command queue is not full;
// each NAL start is one queued command that expands into four results.
// Reset: synchronous active-low aresetn clears control state, prefix size 4.
// ----------------------------------------------------------------------------
module nal_length_to_start_code (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_sample_first,
    input  logic [31:0] s_sample_size,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_valid,
    output logic        m_nal_start,
    output logic        m_sample_end,
    output logic        m_malformed,
    output logic        m_run_last
);
    import nltsc_pkg::*;

    logic q_full, q_push, q_pop, q_head_valid;
    cmd_t q_cmd, q_head;

    nltsc_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_sample_first (s_sample_first),
        .s_sample_size  (s_sample_size),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_cmd          (q_cmd)
    );

    nltsc_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head)
    );

    nltsc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (q_head_valid),
        .head_cmd     (q_head),
        .pop          (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_nal_start  (m_nal_start),
        .m_sample_end (m_sample_end),
        .m_malformed  (m_malformed),
        .m_run_last   (m_run_last)
    );

endmodule

// ===== rtl/nltsc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nltsc_port_checks
// Port-level checks on the result stream of the converter.
// ----------------------------------------------------------------------------
module nltsc_port_checks (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_byte_valid,
    input logic       m_nal_start,
    input logic       m_sample_end,
    input logic       m_malformed,
    input logic       m_run_last
);

    // hold a stalled transfer
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_run_last))
        else $error("stalled result changed");

    a_nal_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_nal_start |-> m_byte_valid && m_out_byte == 8'h00 && !m_run_last)
        else $error("start code does not open with a zero byte");

    a_malformed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_malformed |-> m_sample_end)
        else $error("malformed without sample end");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sample_end |-> m_run_last)
        else $error("sample end not on last result");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_out_byte == 8'h00 && m_sample_end && m_run_last)
        else $error("bad status-only result");

endmodule

bind nal_length_to_start_code nltsc_port_checks u_checker (.*);

// ===== test/nltsc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nltsc_checker
// Watches the configuration, byte and stream channels of the start-code
// converter. Every byte transfer is run through a local model of the
// converter, which queues the stream results it should cause. Every result
// transfer is compared against the oldest queued result.
// ----------------------------------------------------------------------------
module nltsc_checker
    import nltsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_sample_first,
    input  logic [31:0] s_sample_size,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte,
    input  logic        m_byte_valid,
    input  logic        m_nal_start,
    input  logic        m_sample_end,
    input  logic        m_malformed,
    input  logic        m_run_last,
    output int          fail_count,
    output int          pending_results
);

    localparam int REPORT_LIMIT = 10;

    typedef enum logic [1:0] {
        CONV_LENGTH  = 2'd0,
        CONV_PAYLOAD = 2'd1,
        CONV_DISCARD = 2'd2
    } conv_state_e;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       nal_start;
        logic       sample_end;
        logic       malformed;
        logic       run_last;
    } stream_result_t;

    stream_result_t stream_q[$];

    logic [2:0]  prefix_cfg;
    conv_state_e conv_state;
    logic [31:0] len_accum;
    logic [2:0]  len_count;
    logic [31:0] payload_left;
    logic [31:0] sample_left;
    logic        sample_bad;

    int             mismatches = 0;
    stream_result_t got;
    stream_result_t want;

    function automatic stream_result_t stream_byte(input logic [7:0] value,
                                                   input logic carries,
                                                   input logic starts);
        stream_result_t r;
        r            = '0;
        r.out_byte   = value;
        r.byte_valid = carries;
        r.nal_start  = starts;
        return r;
    endfunction

    task automatic convert_byte(input logic [7:0] data, input logic first,
                                input logic [31:0] size);
        stream_result_t burst [4];
        int             n;
        int             i;
        logic [2:0]     width;
        logic [31:0]    remain;
        logic           at_end;
        n = 0;
        width = (prefix_cfg < PREFIX_MIN) ? PREFIX_MIN :
                (prefix_cfg > PREFIX_MAX) ? PREFIX_MAX : prefix_cfg;
        if (first) begin
            sample_left  = (size == 32'd0) ? 32'd1 : size;
            conv_state   = CONV_LENGTH;
            len_accum    = '0;
            len_count    = '0;
            payload_left = '0;
            sample_bad   = 1'b0;
        end
        // bytes outside any sample are dropped silently
        if (sample_left != 32'd0) begin
            remain      = sample_left;
            sample_left = remain - 32'd1;
            at_end      = (sample_left == 32'd0);
            case (conv_state)
                CONV_LENGTH: begin
                    if (len_count == 3'd0 && remain < width) begin
                        sample_bad = 1'b1;
                        conv_state = CONV_DISCARD;
                    end else begin
                        len_accum = {len_accum[23:0], data};
                        if (len_count < 3'd7) len_count = len_count + 3'd1;
                        if (len_count >= width) begin
                            if (len_accum == 32'd0 || len_accum > sample_left) begin
                                sample_bad = 1'b1;
                                conv_state = CONV_DISCARD;
                            end else begin
                                for (i = 0; i < 4; i++) begin
                                    burst[n] = stream_byte(START_CODE[i], 1'b1, i == 0);
                                    n++;
                                end
                                payload_left = len_accum;
                                conv_state   = CONV_PAYLOAD;
                            end
                        end
                    end
                end
                CONV_PAYLOAD: begin
                    burst[n] = stream_byte(data, 1'b1, 1'b0);
                    n++;
                    if (payload_left != 32'd0) payload_left = payload_left - 32'd1;
                    if (payload_left == 32'd0) begin
                        conv_state = CONV_LENGTH;
                        len_accum  = '0;
                        len_count  = '0;
                    end
                end
                default: ;
            endcase
            if (at_end) begin
                // close the sample with a status-only result if nothing else went out
                if (n == 0) begin
                    burst[0] = stream_byte(8'h00, 1'b0, 1'b0);
                    n = 1;
                end
                burst[n-1].sample_end = 1'b1;
                burst[n-1].malformed  = sample_bad;
            end
            if (n > 0) burst[n-1].run_last = 1'b1;
            for (i = 0; i < n; i++) stream_q.insert(stream_q.size(), burst[i]);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            prefix_cfg   = PREFIX_RESET;
            conv_state   = CONV_LENGTH;
            len_accum    = '0;
            len_count    = '0;
            payload_left = '0;
            sample_left  = '0;
            sample_bad   = 1'b0;
            stream_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) prefix_cfg = cfg_data;
            if (s_valid && s_ready) convert_byte(s_data_byte, s_sample_first, s_sample_size);
            if (m_valid && m_ready) begin
                got = '{m_out_byte, m_byte_valid, m_nal_start, m_sample_end,
                        m_malformed, m_run_last};
                if (stream_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected result byte=%02h valid=%0b start=%0b end=%0b bad=%0b last=%0b",
                                 $realtime, got.out_byte, got.byte_valid, got.nal_start,
                                 got.sample_end, got.malformed, got.run_last);
                end else begin
                    want = stream_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: result mismatch exp byte=%02h valid=%0b start=%0b end=%0b bad=%0b last=%0b, got byte=%02h valid=%0b start=%0b end=%0b bad=%0b last=%0b",
                                     $realtime, want.out_byte, want.byte_valid, want.nal_start,
                                     want.sample_end, want.malformed, want.run_last,
                                     got.out_byte, got.byte_valid, got.nal_start,
                                     got.sample_end, got.malformed, got.run_last);
                    end
                end
            end
        end
        fail_count      <= mismatches;
        pending_results <= stream_q.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives length-prefixed samples into the start-code converter: a directed
// run of edge cases, then random samples over every prefix setting and
// several idle patterns on both channels. nltsc_checker does the scoring.
// ----------------------------------------------------------------------------
module tb_top;
    import nltsc_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 18;
    localparam int NUM_PHASES    = 8;

    localparam logic [2:0] PREFIX_PLAN [NUM_PHASES] =
        '{3'd1, 3'd2, 3'd0, 3'd3, 3'd7, 3'd4, 3'd5, 3'd6};

    typedef enum int {
        IDLE_NONE     = 0,
        IDLE_SENDER   = 1,
        IDLE_RECEIVER = 2,
        IDLE_BOTH     = 3
    } idle_mode_e;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_data       = '0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte    = '0;
    logic        s_sample_first = 1'b0;
    logic [31:0] s_sample_size  = '0;
    logic        m_valid;
    logic        m_ready        = 1'b1;
    logic [7:0]  m_out_byte;
    logic        m_byte_valid;
    logic        m_nal_start;
    logic        m_sample_end;
    logic        m_malformed;
    logic        m_run_last;

    int          fail_count;
    int          pending_results;
    int          quiet_cycles = 0;
    int          fed_items    = 0;
    idle_mode_e  idle_mode    = IDLE_NONE;
    logic [7:0]  sample_bytes [$];

    nal_length_to_start_code dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_sample_first (s_sample_first),
        .s_sample_size  (s_sample_size),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_byte_valid   (m_byte_valid),
        .m_nal_start    (m_nal_start),
        .m_sample_end   (m_sample_end),
        .m_malformed    (m_malformed),
        .m_run_last     (m_run_last)
    );

    nltsc_checker u_scoreboard (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_sample_first  (s_sample_first),
        .s_sample_size   (s_sample_size),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_byte_valid    (m_byte_valid),
        .m_nal_start     (m_nal_start),
        .m_sample_end    (m_sample_end),
        .m_malformed     (m_malformed),
        .m_run_last      (m_run_last),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    always @(posedge aclk) begin
        case (idle_mode)
            IDLE_RECEIVER: m_ready <= ($urandom_range(99) >= 46);
            IDLE_BOTH:     m_ready <= ($urandom_range(99) >= 34);
            default:       m_ready <= 1'b1;
        endcase
    end

    // end the run if no transfer of any kind happens for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic first,
                             input logic [31:0] size);
        int pct;
        pct = (idle_mode == IDLE_SENDER) ? 46 : (idle_mode == IDLE_BOTH) ? 34 : 0;
        if ($urandom_range(99) < pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < pct);
        end
        s_valid        <= 1'b1;
        s_data_byte    <= data;
        s_sample_first <= first;
        s_sample_size  <= size;
        do @(posedge aclk); while (!s_ready);
    endtask

    // send the queued bytes; opens marks the first one as a sample start
    task automatic send_run(input logic [31:0] size, input logic opens);
        logic [31:0] span;
        int          i;
        span = (size == 32'd0) ? 32'd1 : size;
        for (i = 0; i < sample_bytes.size(); i++) begin
            if (opens && i == 0) send_byte(sample_bytes[i], 1'b1, size);
            else send_byte(sample_bytes[i], 1'b0, $urandom());
            if (!opens || i < span) fed_items++;
        end
    endtask

    // hold the sender until the stream has caught up, then let it settle
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_prefix(input logic [2:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed samples, with zero lengths, oversize lengths,
    // truncated prefixes, short or huge sample sizes mixed in
    task automatic build_sample(input int width, output logic [31:0] size);
        int          flavor;
        int          units;
        int          bad_unit;
        int          len;
        int          i;
        int          k;
        logic [31:0] len_field;
        sample_bytes.delete();
        flavor   = $urandom_range(9);
        units    = $urandom_range(1, 3);
        bad_unit = $urandom_range(units - 1);
        for (k = 0; k < units; k++) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
            len_field = len;
            if (k == bad_unit && flavor == 6) len_field = '0;
            if (k == bad_unit && flavor == 7) len_field = $urandom();
            for (i = width - 1; i >= 0; i--)
                sample_bytes.insert(sample_bytes.size(), len_field[8*i +: 8]);
            for (i = 0; i < len; i++)
                sample_bytes.insert(sample_bytes.size(), 8'($urandom_range(255)));
        end
        if (flavor == 8) begin
            repeat ((width > 1) ? $urandom_range(1, width - 1) : 1)
                sample_bytes.insert(sample_bytes.size(), 8'($urandom_range(255)));
        end
        size = sample_bytes.size();
        if (flavor == 9) begin
            case ($urandom_range(2))
                0:       if (size > 32'd1) size = size - $urandom_range(1, size - 1);
                1:       size = size + $urandom();
                default: size = '0;
            endcase
        end
    endtask

    initial begin
        int          phase;
        int          width;
        int          sample_no;
        logic [2:0]  setting;
        logic [31:0] size;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // prefix of four bytes out of reset: one clean unit with payload extremes
        sample_bytes = '{8'h00, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h80};
        send_run(32'd6, 1'b1);
        // zero sample size acts as one byte, too short for a length
        sample_bytes = '{8'h5A};
        send_run(32'd0, 1'b1);
        // stray byte after the sample closed
        send_byte(8'hC3, 1'b0, $urandom());
        // zero length
        sample_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h7E};
        send_run(32'd5, 1'b1);
        // huge sample left open, then abandoned by the next start
        sample_bytes = '{8'h01, 8'h02};
        send_run(32'hFFFF_FFFF, 1'b1);
        // shrink the prefix in the middle of a length, then truncate the tail
        sample_bytes = '{8'h00, 8'h00};
        send_run(32'd7, 1'b1);
        drain();
        write_prefix(3'd2);
        sample_bytes = '{8'h03, 8'hAA, 8'hBB, 8'hCC, 8'h11};
        send_run(32'd7, 1'b0);
        // length runs past the sample end
        sample_bytes = '{8'h00, 8'h05, 8'hEE};
        send_run(32'd3, 1'b1);
        drain();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            setting = PREFIX_PLAN[phase];
            write_prefix(setting);
            idle_mode = idle_mode_e'(phase % 4);
            width = (setting < PREFIX_MIN) ? PREFIX_MIN :
                    (setting > PREFIX_MAX) ? PREFIX_MAX : setting;
            fed_items = 0;
            sample_no = 0;
            while (fed_items < PHASE_ITEMS) begin
                build_sample(width, size);
                send_run(size, 1'b1);
                sample_no++;
                if (phase == 2 && sample_no == 2) drain();
            end
            drain();
        end

        if (fail_count == 0 && pending_results == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
